// ----- rtl/ptlr_pkg.sv -----
package ptlr_pkg;

    localparam int CHAR_W = 8;
    localparam int THR_W  = 8;
    localparam int LINE_W = 9;
    localparam int SUM_W  = LINE_W + 1;

    localparam logic [THR_W-1:0]  THR_RESET = 8'd72;

    localparam logic [CHAR_W-1:0] CH_SP = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BS = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_N  = 8'h6E;

    typedef enum logic [1:0] {
        MODE_COLLECT,
        MODE_NEWLINE,
        MODE_RUN,
        MODE_ESCAPE
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_HANDLE,
        S_CHK,
        S_BSP,
        S_BCR,
        S_BLF,
        S_WPRE,
        S_WORD,
        S_WDONE,
        S_SUF1,
        S_SUF2,
        S_POST,
        S_RCR,
        S_RLF,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        SUF_SP,
        SUF_CRLF,
        SUF_BS
    } t_suffix;

    typedef enum logic [1:0] {
        POST_END,
        POST_COLLECT,
        POST_HANDLE,
        POST_NL
    } t_post;

    typedef enum logic [2:0] {
        SEL_WORD,
        SEL_SP,
        SEL_CR,
        SEL_LF,
        SEL_BS
    } t_sel;

    typedef struct packed {
        logic    load;
        logic    emit;
        t_sel    sel;
        logic    k_clr;
        logic    word_done;
        logic    line_clr;
        logic    store;
        logic    fin;
        t_suffix suffix;
    } t_cmd;

    typedef struct packed {
        logic brk_hit;
        logic push_rdy;
        logic word_end;
        logic is_sp;
        logic is_lf;
        logic is_bs;
        logic is_n;
        logic is_end;
    } t_status;

endpackage

// ----- rtl/ptlr_ctrl.sv -----
module ptlr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ptlr_pkg::t_status i_st,
    output ptlr_pkg::t_cmd   o_cmd,
    output logic             o_in_ready
);

    ptlr_pkg::t_state  r_state, n_state;
    ptlr_pkg::t_mode   r_mode, n_mode;
    ptlr_pkg::t_suffix r_suffix, n_suffix;
    ptlr_pkg::t_post   r_post, n_post;
    logic              r_brk, n_brk;
    logic              handle_now;

    // byte handling runs in its own state, or straight from dispatch in collect mode
    assign handle_now = (r_state == ptlr_pkg::S_HANDLE) ||
                        ((r_state == ptlr_pkg::S_DISP) && !i_st.is_end &&
                         (r_mode == ptlr_pkg::MODE_COLLECT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ptlr_pkg::S_IDLE;
            r_mode   <= ptlr_pkg::MODE_COLLECT;
            r_suffix <= ptlr_pkg::SUF_SP;
            r_post   <= ptlr_pkg::POST_END;
            r_brk    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_suffix <= n_suffix;
            r_post   <= n_post;
            r_brk    <= n_brk;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_suffix = r_suffix;
        n_post   = r_post;
        n_brk    = r_brk;
        unique case (r_state)
            ptlr_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ptlr_pkg::S_DISP;
            end
            ptlr_pkg::S_DISP: begin
                if (i_st.is_end) begin
                    n_suffix = ptlr_pkg::SUF_CRLF;
                    n_post   = ptlr_pkg::POST_END;
                    n_state  = ptlr_pkg::S_CHK;
                end else begin
                    unique case (r_mode)
                        ptlr_pkg::MODE_COLLECT: begin
                            n_state = r_state;
                        end
                        ptlr_pkg::MODE_NEWLINE: begin
                            n_suffix = ptlr_pkg::SUF_SP;
                            n_post   = ptlr_pkg::POST_NL;
                            n_state  = ptlr_pkg::S_CHK;
                        end
                        ptlr_pkg::MODE_RUN: begin
                            n_state = ptlr_pkg::S_RCR;
                        end
                        ptlr_pkg::MODE_ESCAPE: begin
                            if (i_st.is_n) begin
                                n_suffix = ptlr_pkg::SUF_CRLF;
                                n_post   = ptlr_pkg::POST_COLLECT;
                            end else begin
                                n_suffix = ptlr_pkg::SUF_BS;
                                n_post   = ptlr_pkg::POST_HANDLE;
                            end
                            n_state = ptlr_pkg::S_CHK;
                        end
                        default: n_state = r_state;
                    endcase
                end
            end
            ptlr_pkg::S_HANDLE: begin
                n_state = r_state;
            end
            ptlr_pkg::S_CHK: begin
                n_brk   = i_st.brk_hit;
                n_state = i_st.brk_hit ? ptlr_pkg::S_BSP : ptlr_pkg::S_WPRE;
            end
            ptlr_pkg::S_BSP: begin
                if (i_st.push_rdy) n_state = ptlr_pkg::S_BCR;
            end
            ptlr_pkg::S_BCR: begin
                if (i_st.push_rdy) n_state = ptlr_pkg::S_BLF;
            end
            ptlr_pkg::S_BLF: begin
                if (i_st.push_rdy) n_state = ptlr_pkg::S_WPRE;
            end
            ptlr_pkg::S_WPRE: begin
                n_state = ptlr_pkg::S_WORD;
            end
            ptlr_pkg::S_WORD: begin
                if (i_st.word_end) n_state = ptlr_pkg::S_WDONE;
            end
            ptlr_pkg::S_WDONE: begin
                n_state = ptlr_pkg::S_SUF1;
            end
            ptlr_pkg::S_SUF1: begin
                if (i_st.push_rdy) begin
                    n_state = (r_suffix == ptlr_pkg::SUF_CRLF) ? ptlr_pkg::S_SUF2
                                                               : ptlr_pkg::S_POST;
                end
            end
            ptlr_pkg::S_SUF2: begin
                if (i_st.push_rdy) n_state = ptlr_pkg::S_POST;
            end
            ptlr_pkg::S_POST: begin
                unique case (r_post) inside
                    ptlr_pkg::POST_END, ptlr_pkg::POST_COLLECT: begin
                        n_mode  = ptlr_pkg::MODE_COLLECT;
                        n_state = ptlr_pkg::S_FIN;
                    end
                    ptlr_pkg::POST_HANDLE: begin
                        n_state = ptlr_pkg::S_HANDLE;
                    end
                    ptlr_pkg::POST_NL: begin
                        if (i_st.is_lf) begin
                            // a break already ended the line: no extra CR LF
                            n_mode  = ptlr_pkg::MODE_RUN;
                            n_state = r_brk ? ptlr_pkg::S_FIN : ptlr_pkg::S_RCR;
                        end else begin
                            n_state = ptlr_pkg::S_HANDLE;
                        end
                    end
                    default: n_state = ptlr_pkg::S_FIN;
                endcase
            end
            ptlr_pkg::S_RCR: begin
                if (i_st.push_rdy) n_state = ptlr_pkg::S_RLF;
            end
            ptlr_pkg::S_RLF: begin
                if (i_st.push_rdy) begin
                    n_state = i_st.is_lf ? ptlr_pkg::S_FIN : ptlr_pkg::S_HANDLE;
                end
            end
            ptlr_pkg::S_FIN: begin
                if (i_st.push_rdy) n_state = ptlr_pkg::S_IDLE;
            end
            default: n_state = ptlr_pkg::S_IDLE;
        endcase

        if (handle_now) begin
            if (i_st.is_sp) begin
                n_suffix = ptlr_pkg::SUF_SP;
                n_post   = ptlr_pkg::POST_COLLECT;
                n_state  = ptlr_pkg::S_CHK;
            end else begin
                if (i_st.is_lf)      n_mode = ptlr_pkg::MODE_NEWLINE;
                else if (i_st.is_bs) n_mode = ptlr_pkg::MODE_ESCAPE;
                else                 n_mode = ptlr_pkg::MODE_COLLECT;
                n_state = i_st.push_rdy ? ptlr_pkg::S_IDLE : ptlr_pkg::S_FIN;
            end
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.sel    = ptlr_pkg::SEL_SP;
        o_cmd.suffix = r_suffix;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ptlr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ptlr_pkg::S_BSP: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = ptlr_pkg::SEL_SP;
            end
            ptlr_pkg::S_BCR: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = ptlr_pkg::SEL_CR;
            end
            ptlr_pkg::S_BLF: begin
                o_cmd.emit     = 1'b1;
                o_cmd.sel      = ptlr_pkg::SEL_LF;
                o_cmd.line_clr = 1'b1;
            end
            ptlr_pkg::S_WPRE: begin
                o_cmd.k_clr = 1'b1;
            end
            ptlr_pkg::S_WORD: begin
                o_cmd.emit = !i_st.word_end;
                o_cmd.sel  = ptlr_pkg::SEL_WORD;
            end
            ptlr_pkg::S_WDONE: begin
                o_cmd.word_done = 1'b1;
            end
            ptlr_pkg::S_SUF1: begin
                o_cmd.emit = 1'b1;
                unique case (r_suffix)
                    ptlr_pkg::SUF_SP:   o_cmd.sel = ptlr_pkg::SEL_SP;
                    ptlr_pkg::SUF_CRLF: o_cmd.sel = ptlr_pkg::SEL_CR;
                    ptlr_pkg::SUF_BS:   o_cmd.sel = ptlr_pkg::SEL_BS;
                    default:            o_cmd.sel = ptlr_pkg::SEL_SP;
                endcase
            end
            ptlr_pkg::S_SUF2: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = ptlr_pkg::SEL_LF;
            end
            ptlr_pkg::S_POST: begin
                o_cmd.line_clr = (r_post == ptlr_pkg::POST_END);
            end
            ptlr_pkg::S_RCR: begin
                o_cmd.emit = 1'b1;
                o_cmd.sel  = ptlr_pkg::SEL_CR;
            end
            ptlr_pkg::S_RLF: begin
                o_cmd.emit     = 1'b1;
                o_cmd.sel      = ptlr_pkg::SEL_LF;
                o_cmd.line_clr = 1'b1;
            end
            ptlr_pkg::S_FIN: begin
                o_cmd.fin = 1'b1;
            end
            default: o_cmd.fin = 1'b0;
        endcase

        if (handle_now) begin
            o_cmd.store = !i_st.is_sp && !i_st.is_lf && !i_st.is_bs;
            o_cmd.fin   = !i_st.is_sp;
        end
    end

endmodule

// ----- rtl/ptlr_dp.sv -----
module ptlr_dp #(
    parameter int WORD_MAX = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptlr_pkg::t_cmd                i_cmd,
    output ptlr_pkg::t_status             o_st,
    input  logic [ptlr_pkg::CHAR_W-1:0]   i_char_in,
    input  logic                          i_end_of_body,
    input  logic                          i_cfg_valid,
    input  logic [ptlr_pkg::THR_W-1:0]    i_cfg_wrap_threshold,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ptlr_pkg::CHAR_W-1:0]   o_out_char,
    output logic                          o_last_of_run,
    output logic                          o_word_overflow
);

    localparam int KW = $clog2(WORD_MAX + 1);
    localparam int AW = $clog2(WORD_MAX);

    logic [ptlr_pkg::CHAR_W-1:0] r_mem [WORD_MAX];
    logic [ptlr_pkg::CHAR_W-1:0] r_rd;
    logic [ptlr_pkg::CHAR_W-1:0] r_c;
    logic                        r_end;
    logic [ptlr_pkg::THR_W-1:0]  r_thr;
    logic [KW-1:0]               r_wlen;
    logic [KW-1:0]               r_k;
    logic [ptlr_pkg::LINE_W-1:0] r_line;
    logic                        r_ovf;
    logic [ptlr_pkg::CHAR_W-1:0] r_h_char;
    logic                        r_h_ovf;
    logic                        r_h_valid;
    logic [ptlr_pkg::CHAR_W-1:0] r_o_char;
    logic                        r_o_last;
    logic                        r_o_ovf;
    logic                        r_o_valid;

    logic [ptlr_pkg::SUM_W-1:0]  sum;
    logic [1:0]                  slen;
    logic                        out_free;
    logic                        push_rdy;
    logic                        emit_fire;
    logic                        fin_fire;
    logic [KW-1:0]               rd_next;
    logic [AW-1:0]               rd_addr;
    logic [ptlr_pkg::CHAR_W-1:0] emit_char;

    assign slen     = (i_cmd.suffix == ptlr_pkg::SUF_CRLF) ? 2'd2 : 2'd1;
    assign sum      = ptlr_pkg::SUM_W'(r_line) + ptlr_pkg::SUM_W'(r_wlen)
                    + ptlr_pkg::SUM_W'(slen);
    assign out_free = !r_o_valid || i_out_ready;
    assign push_rdy = !r_h_valid || out_free;
    assign emit_fire = i_cmd.emit && push_rdy;
    assign fin_fire  = i_cmd.fin && push_rdy;

    assign o_st.brk_hit  = (sum >= ptlr_pkg::SUM_W'(r_thr));
    assign o_st.push_rdy = push_rdy;
    assign o_st.word_end = (r_k == r_wlen);
    assign o_st.is_sp    = (r_c == ptlr_pkg::CH_SP);
    assign o_st.is_lf    = (r_c == ptlr_pkg::CH_LF);
    assign o_st.is_bs    = (r_c == ptlr_pkg::CH_BS);
    assign o_st.is_n     = (r_c == ptlr_pkg::CH_N);
    assign o_st.is_end   = r_end;

    // read one entry ahead so the word streams at one byte a cycle while the output is not stalled
    always_comb begin
        if (i_cmd.k_clr) begin
            rd_next = '0;
        end else if (emit_fire && (i_cmd.sel == ptlr_pkg::SEL_WORD)) begin
            rd_next = r_k + KW'(1);
        end else begin
            rd_next = r_k;
        end
        if (rd_next >= KW'(WORD_MAX)) rd_next = '0;
    end
    assign rd_addr = rd_next[AW-1:0];

    always_comb begin
        case (i_cmd.sel)
            ptlr_pkg::SEL_WORD: emit_char = r_rd;
            ptlr_pkg::SEL_SP:   emit_char = ptlr_pkg::CH_SP;
            ptlr_pkg::SEL_CR:   emit_char = ptlr_pkg::CH_CR;
            ptlr_pkg::SEL_LF:   emit_char = ptlr_pkg::CH_LF;
            ptlr_pkg::SEL_BS:   emit_char = ptlr_pkg::CH_BS;
            default:            emit_char = ptlr_pkg::CH_SP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[rd_addr];
        if (i_cmd.store && (r_wlen < KW'(WORD_MAX))) begin
            r_mem[r_wlen[AW-1:0]] <= r_c;
        end
        if (i_cmd.load) begin
            r_c   <= i_char_in;
            r_end <= i_end_of_body;
        end
        if (emit_fire) begin
            r_h_char <= emit_char;
            r_h_ovf  <= r_ovf;
        end
        if (out_free && r_h_valid && (emit_fire || fin_fire)) begin
            r_o_char <= r_h_char;
            r_o_ovf  <= r_h_ovf;
            r_o_last <= fin_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= ptlr_pkg::THR_RESET;
            r_wlen    <= '0;
            r_k       <= '0;
            r_line    <= '0;
            r_ovf     <= 1'b0;
            r_h_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_thr <= i_cfg_wrap_threshold;

            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (emit_fire && (i_cmd.sel == ptlr_pkg::SEL_WORD)) begin
                r_k <= r_k + KW'(1);
            end

            if (i_cmd.word_done) begin
                r_line <= ptlr_pkg::LINE_W'(sum);
                r_wlen <= '0;
                r_ovf  <= 1'b0;
            end else if (i_cmd.line_clr) begin
                r_line <= '0;
            end else if (i_cmd.store) begin
                if (r_wlen < KW'(WORD_MAX)) r_wlen <= r_wlen + KW'(1);
                else                        r_ovf  <= 1'b1;
            end

            // hold the newest byte back until we know whether it ends the run
            if (emit_fire)     r_h_valid <= 1'b1;
            else if (fin_fire) r_h_valid <= 1'b0;

            if (out_free) r_o_valid <= r_h_valid && (emit_fire || fin_fire);
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_out_char      = r_o_char;
    assign o_last_of_run   = r_o_last;
    assign o_word_overflow = r_o_ovf;

endmodule

// ----- rtl/plain_text_line_reflow_unit.sv -----
// A plain word byte is taken through accept (IDLE) and dispatch; a flush runs through
// the control states and emits each byte in turn (break, word, suffix).
// The unit takes a new item only once the last one is done; the longest item is
// a newline or escape that flushes twice with a full word and two breaks.
// Reset (synchronous, active low): collect mode, empty word, line length 0,
// threshold 72, output empty. The word buffer itself is not cleared.
module plain_text_line_reflow_unit #(
    parameter int WORD_MAX = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_end_of_body,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_wrap_threshold,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run,
    output logic       o_word_overflow
);

    ptlr_pkg::t_cmd    cmd;
    ptlr_pkg::t_status st;

    assign o_cfg_ready = 1'b1;

    ptlr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    ptlr_dp #(
        .WORD_MAX (WORD_MAX)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_st                 (st),
        .i_char_in            (i_char_in),
        .i_end_of_body        (i_end_of_body),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_wrap_threshold (i_cfg_wrap_threshold),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_out_char           (o_out_char),
        .o_last_of_run        (o_last_of_run),
        .o_word_overflow      (o_word_overflow)
    );

endmodule

// ----- rtl/ptlr_checker.sv -----
module ptlr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_char,
    input logic       o_last_of_run,
    input logic       o_word_overflow
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_char) && $stable(o_last_of_run))
        else $error("stalled output item changed");

    // one item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after accept");

    // every run ends on a suffix byte: space, LF or backslash
    a_last_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_run |->
            (o_out_char == 8'h20) || (o_out_char == 8'h0A) || (o_out_char == 8'h5C))
        else $error("run ends on a non-suffix byte");

    // the flag is cleared before the suffix goes out
    a_last_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_run |-> !o_word_overflow)
        else $error("overflow flag on final byte of run");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind plain_text_line_reflow_unit ptlr_checker u_ptlr_checker (.*);
